// ===== design/tvs_pkg.sv =====
// Shared types, constants and the arctangent table of the turtle vector step block.
`default_nettype none

package tvs_pkg;

	// Fixed-point formats
	localparam int FRAC_BITS   = 8;
	localparam int AMOUNT_W    = 24;
	localparam int COORD_W     = 32;
	localparam int HEADING_W   = 17;
	localparam int COLOUR_W    = 8;

	// Iterative unit sizes
	localparam int TABLE_LEN         = 24;
	localparam int CORDIC_ITERATIONS = 16;
	localparam int COR_STEPS  = (CORDIC_ITERATIONS < TABLE_LEN) ? CORDIC_ITERATIONS : TABLE_LEN;
	localparam int STEP_W     = 5;
	localparam int ROT_STEPS  = 9;

	// Datapath widths: CORDIC vector in Q2.30, angle in Q.16 degrees, product accumulator
	localparam int VEC_W   = 33;
	localparam int Z_W     = 27;
	localparam int ATAN_W  = 23;
	localparam int PART_W  = 18;
	localparam int PROD_W  = AMOUNT_W + PART_W;
	localparam int ACC_W   = 58;
	localparam int LO_W    = 17;
	localparam int DISP_W  = ACC_W - 30;

	// Angle constants in heading units
	localparam int FULL_TURN    = 360 << FRAC_BITS;
	localparam int HALF_TURN    = 180 << FRAC_BITS;
	localparam int QUARTER_TURN = 90 << FRAC_BITS;
	localparam int Z_SHIFT      = 16 - FRAC_BITS;

	// Numeric constants
	localparam logic signed [VEC_W-1:0] CORDIC_START = 33'sd652032874;
	localparam logic signed [ACC_W-1:0] ACC_ROUND    = 58'sd536870912;

	// Reset values of the pen attributes
	localparam logic [COLOUR_W-1:0] FG_RESET      = 8'd7;
	localparam logic [COLOUR_W-1:0] BG_RESET      = 8'd0;
	localparam logic [COLOUR_W-1:0] PATTERN_RESET = 8'd43;

	// Action codes
	localparam logic [2:0] ACT_ROTATE  = 3'd0;
	localparam logic [2:0] ACT_MOVE    = 3'd1;
	localparam logic [2:0] ACT_DRAW    = 3'd2;
	localparam logic [2:0] ACT_FG      = 3'd3;
	localparam logic [2:0] ACT_BG      = 3'd4;
	localparam logic [2:0] ACT_PATTERN = 3'd5;

	// Command word
	typedef struct packed {
		logic [2:0]                 action;
		logic signed [AMOUNT_W-1:0] amount;
		logic [7:0]                 symbol;
	} cmd_word_t;

	// Report word
	typedef struct packed {
		logic signed [COORD_W-1:0] start_x;
		logic signed [COORD_W-1:0] start_y;
		logic signed [COORD_W-1:0] end_x;
		logic signed [COORD_W-1:0] end_y;
		logic                      segment_drawn;
		logic                      segment_moved;
		logic [HEADING_W-1:0]      heading_out;
		logic [COLOUR_W-1:0]       fg_out;
		logic [COLOUR_W-1:0]       bg_out;
		logic [7:0]                pattern_out;
	} rpt_word_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic              capture;
		logic              rot_prep;
		logic              rot_step;
		logic              rot_last;
		logic              cor_prep;
		logic              cor_iter;
		logic              cor_neg;
		logic              mul_en;
		logic [1:0]        mul_sel;
		logic              acc_en;
		logic [1:0]        acc_sel;
		logic              pos_update;
		logic              attr_set;
		logic              rpt_load;
		logic [STEP_W-1:0] step;
	} tvs_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic rpt_free;
	} tvs_status_t;

	// Arctangent of 2^-i in degrees, Q.16, rounded
	function automatic logic [ATAN_W-1:0] atan_deg_q16(input logic [STEP_W-1:0] idx);
		logic [ATAN_W-1:0] r;
		unique case (idx)
			5'd0:    r = 23'd2949120;
			5'd1:    r = 23'd1740967;
			5'd2:    r = 23'd919879;
			5'd3:    r = 23'd466945;
			5'd4:    r = 23'd234379;
			5'd5:    r = 23'd117304;
			5'd6:    r = 23'd58666;
			5'd7:    r = 23'd29335;
			5'd8:    r = 23'd14668;
			5'd9:    r = 23'd7334;
			5'd10:   r = 23'd3667;
			5'd11:   r = 23'd1833;
			5'd12:   r = 23'd917;
			5'd13:   r = 23'd458;
			5'd14:   r = 23'd229;
			5'd15:   r = 23'd115;
			5'd16:   r = 23'd57;
			5'd17:   r = 23'd29;
			5'd18:   r = 23'd14;
			5'd19:   r = 23'd7;
			5'd20:   r = 23'd4;
			5'd21:   r = 23'd2;
			5'd22:   r = 23'd1;
			default: r = 23'd0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== design/tvs_ctrl.sv =====
// Sequencing state machine of the turtle vector step block.
`default_nettype none

module tvs_ctrl #(
	parameter int CORDIC_ITERATIONS = tvs_pkg::CORDIC_ITERATIONS
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cmd_valid,
	input  wire logic [2:0]          cmd_action,
	output logic                     cmd_ready,
	input  wire tvs_pkg::tvs_status_t status,
	output tvs_pkg::tvs_cmd_t        ctl
);

	localparam logic [3:0] ST_IDLE     = 4'd0;
	localparam logic [3:0] ST_ROT_PREP = 4'd1;
	localparam logic [3:0] ST_ROT_STEP = 4'd2;
	localparam logic [3:0] ST_COR_PREP = 4'd3;
	localparam logic [3:0] ST_COR_ITER = 4'd4;
	localparam logic [3:0] ST_COR_NEG  = 4'd5;
	localparam logic [3:0] ST_MUL      = 4'd6;
	localparam logic [3:0] ST_UPDATE   = 4'd7;
	localparam logic [3:0] ST_ATTR     = 4'd8;
	localparam logic [3:0] ST_REPORT   = 4'd9;

	// The arctangent table limits the number of micro-rotations
	localparam int COR_STEPS = (CORDIC_ITERATIONS < tvs_pkg::TABLE_LEN) ?
		CORDIC_ITERATIONS : tvs_pkg::TABLE_LEN;

	localparam logic [tvs_pkg::STEP_W-1:0] COR_LAST =
		tvs_pkg::STEP_W'(COR_STEPS - 1);
	localparam logic [tvs_pkg::STEP_W-1:0] ROT_FIRST =
		tvs_pkg::STEP_W'(tvs_pkg::ROT_STEPS - 1);
	localparam logic [tvs_pkg::STEP_W-1:0] MUL_LAST = 5'd4;

	logic [3:0]                  state_q;
	logic [3:0]                  state_nxt;
	logic [tvs_pkg::STEP_W-1:0]  cnt_q;
	logic [tvs_pkg::STEP_W-1:0]  cnt_nxt;
	logic                        accept;

	assign cmd_ready = (state_q == ST_IDLE);
	assign accept    = cmd_valid && cmd_ready;

	// Next state, step counter and datapath commands
	always_comb begin
		state_nxt = state_q;
		cnt_nxt   = cnt_q;
		ctl       = '0;
		ctl.step  = cnt_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					ctl.capture = 1'b1;
					unique case (cmd_action) inside
						tvs_pkg::ACT_ROTATE:                 state_nxt = ST_ROT_PREP;
						tvs_pkg::ACT_MOVE, tvs_pkg::ACT_DRAW: state_nxt = ST_COR_PREP;
						default:                             state_nxt = ST_ATTR;
					endcase
				end
			end
			ST_ROT_PREP: begin
				ctl.rot_prep = 1'b1;
				cnt_nxt      = ROT_FIRST;
				state_nxt    = ST_ROT_STEP;
			end
			ST_ROT_STEP: begin
				ctl.rot_step = 1'b1;
				if (cnt_q == '0) begin
					ctl.rot_last = 1'b1;
					state_nxt    = ST_REPORT;
				end else begin
					cnt_nxt = cnt_q - 1'b1;
				end
			end
			ST_COR_PREP: begin
				ctl.cor_prep = 1'b1;
				cnt_nxt      = '0;
				state_nxt    = ST_COR_ITER;
			end
			ST_COR_ITER: begin
				ctl.cor_iter = 1'b1;
				if (cnt_q == COR_LAST) begin
					state_nxt = ST_COR_NEG;
				end else begin
					cnt_nxt = cnt_q + 1'b1;
				end
			end
			ST_COR_NEG: begin
				ctl.cor_neg = 1'b1;
				cnt_nxt     = '0;
				state_nxt   = ST_MUL;
			end
			ST_MUL: begin
				// Products are formed one step ahead of their accumulation
				ctl.mul_en  = (cnt_q != MUL_LAST);
				ctl.mul_sel = cnt_q[1:0];
				ctl.acc_en  = (cnt_q != '0);
				ctl.acc_sel = 2'(cnt_q - 1'b1);
				if (cnt_q == MUL_LAST) begin
					state_nxt = ST_UPDATE;
				end else begin
					cnt_nxt = cnt_q + 1'b1;
				end
			end
			ST_UPDATE: begin
				ctl.pos_update = 1'b1;
				state_nxt      = ST_REPORT;
			end
			ST_ATTR: begin
				ctl.attr_set = 1'b1;
				state_nxt    = ST_REPORT;
			end
			ST_REPORT: begin
				if (status.rpt_free) begin
					ctl.rpt_load = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// State and counter registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nxt;
			cnt_q   <= cnt_nxt;
		end
	end

endmodule

`default_nettype wire

// ===== design/tvs_datapath.sv =====
// Turtle state, CORDIC, multiply-accumulate and report register of the turtle vector step block.
`default_nettype none

module tvs_datapath (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire tvs_pkg::tvs_cmd_t    ctl,
	input  wire tvs_pkg::cmd_word_t   cmd_word,
	output tvs_pkg::tvs_status_t      status,
	output logic                      rpt_valid,
	input  wire logic                 rpt_ready,
	output tvs_pkg::rpt_word_t        rpt_word
);

	localparam int VW = tvs_pkg::VEC_W;
	localparam int ZW = tvs_pkg::Z_W;
	localparam int AW = tvs_pkg::ACC_W;
	localparam int CW = tvs_pkg::COORD_W;
	localparam int HW = tvs_pkg::HEADING_W + 1;

	localparam logic signed [ZW-1:0] ROT_UNIT = ZW'(tvs_pkg::FULL_TURN);
	localparam logic signed [ZW-1:0] ROT_BIAS = ZW'(tvs_pkg::FULL_TURN << (tvs_pkg::ROT_STEPS - 2));
	localparam logic signed [HW-1:0] H_FULL    = HW'(tvs_pkg::FULL_TURN);
	localparam logic signed [HW-1:0] H_HALF    = HW'(tvs_pkg::HALF_TURN);
	localparam logic signed [HW-1:0] H_QUARTER = HW'(tvs_pkg::QUARTER_TURN);

	// Architectural state
	logic [tvs_pkg::HEADING_W-1:0] heading_q;
	logic signed [CW-1:0]          pos_x_q;
	logic signed [CW-1:0]          pos_y_q;
	logic [tvs_pkg::COLOUR_W-1:0]  fg_q;
	logic [tvs_pkg::COLOUR_W-1:0]  bg_q;
	logic [7:0]                    pattern_q;

	// Per-command working registers
	logic [2:0]                           act_q;
	logic signed [tvs_pkg::AMOUNT_W-1:0]  amt_q;
	logic [7:0]                           sym_q;
	logic signed [CW-1:0]                 start_x_q;
	logic signed [CW-1:0]                 start_y_q;
	logic                                 moved_q;
	logic                                 drawn_q;
	logic signed [VW-1:0]                 x_q;
	logic signed [VW-1:0]                 y_q;
	logic signed [ZW-1:0]                 z_q;
	logic                                 neg_q;
	logic signed [tvs_pkg::PROD_W-1:0]    mul_q;
	logic signed [AW-1:0]                 acc_x_q;
	logic signed [AW-1:0]                 acc_y_q;

	// Report register
	tvs_pkg::rpt_word_t rpt_q;
	logic               rpt_valid_q;

	// Combinational helpers
	logic signed [ZW-1:0]                 rot_diff;
	logic signed [ZW-1:0]                 rot_init;
	logic signed [ZW-1:0]                 rot_wrap;
	logic signed [ZW-1:0]                 rot_next;
	logic signed [HW-1:0]                 h_signed;
	logic signed [HW-1:0]                 h_half;
	logic signed [HW-1:0]                 h_fold;
	logic                                 h_neg;
	logic signed [VW-1:0]                 x_sh;
	logic signed [VW-1:0]                 y_sh;
	logic signed [ZW-1:0]                 atan_z;
	logic signed [VW-1:0]                 mul_src;
	logic signed [tvs_pkg::PART_W-1:0]    mul_part;
	logic signed [AW-1:0]                 acc_term;
	logic signed [tvs_pkg::DISP_W-1:0]    disp_x;
	logic signed [tvs_pkg::DISP_W-1:0]    disp_y;
	logic signed [CW:0]                   sum_x;
	logic signed [CW:0]                   sum_y;
	logic signed [CW-1:0]                 new_x;
	logic signed [CW-1:0]                 new_y;
	logic [tvs_pkg::COLOUR_W-1:0]         colour;

	// Saturate a 33-bit sum to the signed 32-bit range
	function automatic logic signed [CW-1:0] sat_coord(input logic signed [CW:0] v);
		logic signed [CW-1:0] r;
		if (v[CW] != v[CW-1]) begin
			r = v[CW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
		end else begin
			r = v[CW-1:0];
		end
		return r;
	endfunction

	// Heading minus amount, brought to a non-negative value with a whole number of turns
	assign rot_diff = ZW'($signed({1'b0, heading_q})) - ZW'(amt_q);
	assign rot_init = rot_diff[ZW-1] ? (rot_diff + ROT_BIAS) : rot_diff;

	// One restoring step of the modulo-360 reduction
	assign rot_wrap = ROT_UNIT <<< ctl.step;
	assign rot_next = (z_q >= rot_wrap) ? (z_q - rot_wrap) : z_q;

	// Fold the heading into the range of minus to plus a quarter turn
	always_comb begin
		h_signed = $signed({1'b0, heading_q});
		h_half   = (h_signed > H_HALF) ? (h_signed - H_FULL) : h_signed;
		h_neg    = 1'b0;
		h_fold   = h_half;
		if (h_half > H_QUARTER) begin
			h_fold = h_half - H_HALF;
			h_neg  = 1'b1;
		end else if (h_half < -H_QUARTER) begin
			h_fold = h_half + H_HALF;
			h_neg  = 1'b1;
		end
	end

	// CORDIC micro-rotation operands
	assign x_sh   = x_q >>> ctl.step;
	assign y_sh   = y_q >>> ctl.step;
	assign atan_z = ZW'(tvs_pkg::atan_deg_q16(ctl.step));

	// Partial product operand: low 17 bits unsigned, upper bits signed
	assign mul_src  = ctl.mul_sel[1] ? y_q : x_q;
	assign mul_part = ctl.mul_sel[0] ?
		tvs_pkg::PART_W'($signed(mul_src[VW-1:tvs_pkg::LO_W])) :
		$signed({1'b0, mul_src[tvs_pkg::LO_W-1:0]});
	assign acc_term = ctl.acc_sel[0] ? (AW'(mul_q) <<< tvs_pkg::LO_W) : AW'(mul_q);

	// New position with rounding already folded into the accumulators
	assign disp_x = acc_x_q[AW-1:30];
	assign disp_y = acc_y_q[AW-1:30];
	assign sum_x  = (CW+1)'(pos_x_q) + (CW+1)'(disp_x);
	assign sum_y  = (CW+1)'(pos_y_q) + (CW+1)'(disp_y);
	assign new_x  = sat_coord(sum_x);
	assign new_y  = sat_coord(sum_y);

	// Colour: integer part of the amount, clamped to one byte
	always_comb begin
		if (amt_q[tvs_pkg::AMOUNT_W-1]) begin
			colour = '0;
		end else if ((amt_q >>> tvs_pkg::FRAC_BITS) > 24'sd255) begin
			colour = '1;
		end else begin
			colour = amt_q[tvs_pkg::FRAC_BITS +: tvs_pkg::COLOUR_W];
		end
	end

	// Architectural turtle state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heading_q <= '0;
			pos_x_q   <= '0;
			pos_y_q   <= '0;
			fg_q      <= tvs_pkg::FG_RESET;
			bg_q      <= tvs_pkg::BG_RESET;
			pattern_q <= tvs_pkg::PATTERN_RESET;
		end else begin
			if (ctl.rot_step && ctl.rot_last) begin
				heading_q <= rot_next[tvs_pkg::HEADING_W-1:0];
			end
			if (ctl.pos_update) begin
				pos_x_q <= new_x;
				pos_y_q <= new_y;
			end
			if (ctl.attr_set) begin
				unique case (act_q)
					tvs_pkg::ACT_FG:      fg_q      <= colour;
					tvs_pkg::ACT_BG:      bg_q      <= colour;
					tvs_pkg::ACT_PATTERN: pattern_q <= sym_q;
					default: begin
					end
				endcase
			end
		end
	end

	// Working registers of the current command
	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			act_q     <= cmd_word.action;
			amt_q     <= cmd_word.amount;
			sym_q     <= cmd_word.symbol;
			start_x_q <= pos_x_q;
			start_y_q <= pos_y_q;
			moved_q   <= 1'b0;
			drawn_q   <= 1'b0;
		end
		if (ctl.rot_prep) begin
			z_q <= rot_init;
		end
		if (ctl.rot_step) begin
			z_q <= rot_next;
		end
		if (ctl.cor_prep) begin
			x_q     <= tvs_pkg::CORDIC_START;
			y_q     <= '0;
			z_q     <= ZW'(h_fold) <<< tvs_pkg::Z_SHIFT;
			neg_q   <= h_neg;
			acc_x_q <= tvs_pkg::ACC_ROUND;
			acc_y_q <= tvs_pkg::ACC_ROUND;
		end
		if (ctl.cor_iter) begin
			if (!z_q[ZW-1]) begin
				x_q <= x_q - y_sh;
				y_q <= y_q + x_sh;
				z_q <= z_q - atan_z;
			end else begin
				x_q <= x_q + y_sh;
				y_q <= y_q - x_sh;
				z_q <= z_q + atan_z;
			end
		end
		if (ctl.cor_neg && neg_q) begin
			x_q <= -x_q;
			y_q <= -y_q;
		end
		if (ctl.mul_en) begin
			mul_q <= amt_q * mul_part;
		end
		if (ctl.acc_en) begin
			if (ctl.acc_sel[1]) begin
				acc_y_q <= acc_y_q + acc_term;
			end else begin
				acc_x_q <= acc_x_q + acc_term;
			end
		end
		if (ctl.pos_update) begin
			moved_q <= (new_x != pos_x_q) || (new_y != pos_y_q);
			drawn_q <= ((new_x != pos_x_q) || (new_y != pos_y_q)) && (act_q == tvs_pkg::ACT_DRAW);
		end
	end

	// Report register and its valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rpt_valid_q <= 1'b0;
		end else if (ctl.rpt_load) begin
			rpt_valid_q <= 1'b1;
		end else if (rpt_ready) begin
			rpt_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rpt_load) begin
			rpt_q.start_x       <= start_x_q;
			rpt_q.start_y       <= start_y_q;
			rpt_q.end_x         <= pos_x_q;
			rpt_q.end_y         <= pos_y_q;
			rpt_q.segment_drawn <= drawn_q;
			rpt_q.segment_moved <= moved_q;
			rpt_q.heading_out   <= heading_q;
			rpt_q.fg_out        <= fg_q;
			rpt_q.bg_out        <= bg_q;
			rpt_q.pattern_out   <= pattern_q;
		end
	end

	assign status.rpt_free = !rpt_valid_q || rpt_ready;
	assign rpt_valid       = rpt_valid_q;
	assign rpt_word        = rpt_q;

endmodule

`default_nettype wire

// ===== design/turtle_vector_step.sv =====
// Top level of the turtle vector step block: controller and datapath.
//
//  Channel | Signals                        | Word type
//  --------+--------------------------------+---------------------
//  command | cmd_valid, cmd_ready, cmd_word | tvs_pkg::cmd_word_t
//  report  | rpt_valid, rpt_ready, rpt_word | tvs_pkg::rpt_word_t
//
// One command word is worked on at a time; cmd_ready is high while the controller is idle.
// Rotate runs nine restoring steps of the modulo-360 reduction; move and draw run the
// iterative CORDIC and then the shared 24 x 18 multiplier; pen attribute commands set
// the attribute directly.
// A report word waits in its own register, so the next command is taken while it is
// pending; a command finishes only once that register is free.
// Reset puts the turtle at the origin, heading zero, foreground 7, background 0, pattern '+'.
`default_nettype none

module turtle_vector_step #(
	parameter int CORDIC_ITERATIONS = tvs_pkg::CORDIC_ITERATIONS
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cmd_valid,
	output logic                    cmd_ready,
	input  wire tvs_pkg::cmd_word_t cmd_word,
	output logic                    rpt_valid,
	input  wire logic               rpt_ready,
	output tvs_pkg::rpt_word_t      rpt_word
);

	tvs_pkg::tvs_cmd_t    ctl;
	tvs_pkg::tvs_status_t status;

	// Sequencer
	tvs_ctrl #(
		.CORDIC_ITERATIONS (CORDIC_ITERATIONS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_action (cmd_word.action),
		.cmd_ready  (cmd_ready),
		.status     (status),
		.ctl        (ctl)
	);

	// Arithmetic and state
	tvs_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.cmd_word  (cmd_word),
		.status    (status),
		.rpt_valid (rpt_valid),
		.rpt_ready (rpt_ready),
		.rpt_word  (rpt_word)
	);

endmodule

`default_nettype wire
